[rtl/core/diffusion_reaction_stencil_unit_assert.svh]
// Assertion macros used by the stencil unit checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef DIFFUSION_REACTION_STENCIL_UNIT_ASSERT_SVH
`define DIFFUSION_REACTION_STENCIL_UNIT_ASSERT_SVH

// same-cycle implication
`define DRS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stencil unit check failed");

// next-cycle implication
`define DRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stencil unit check failed");

`endif

[rtl/core/drs_pkg.sv]
// Types and constants of the diffusion-reaction stencil unit.
// No dependencies; used by the top level and its checker.
package drs_pkg;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_PREPARE = 2'd1;
	localparam logic [1:0] KIND_UPDATE  = 2'd2;

	localparam logic [1:0] MODE_DIRICHLET = 2'd0;
	localparam logic [1:0] MODE_NEUMANN   = 2'd1;

	localparam logic [2:0] REG_DIRICHLET_X  = 3'd0;
	localparam logic [2:0] REG_DIRICHLET_Y  = 3'd1;
	localparam logic [2:0] REG_DIRICHLET_Z  = 3'd2;
	localparam logic [2:0] REG_BOUNDARY     = 3'd3;
	localparam logic [2:0] REG_GAIN         = 3'd4;
	localparam logic [2:0] REG_TIME_STEP    = 3'd5;
	localparam logic [2:0] REG_ROW_LENGTH   = 3'd6;
	localparam logic [2:0] REG_PLANE_LENGTH = 3'd7;

	localparam int NUM_FACES = 6;

	typedef struct packed {
		logic [1:0]         kind;
		logic [14:0]        cell_index;
		logic [31:0]        concentration;
		logic signed [31:0] reaction;
		logic [5:0]         face_flags;
		logic               ghost_flag;
	} item_t;

	typedef struct packed {
		logic [14:0] result_index;
		logic [31:0] new_concentration;
		logic [31:0] relative_change;
		logic [31:0] max_change;
		logic        zero_divide;
	} result_t;

endpackage

[rtl/core/diffusion_reaction_stencil_unit.sv]
// Diffusion-reaction stencil unit: cell stores, boundary handling, explicit update.
// Depends on drs_pkg.
//
// Usage: an item (load, prepare or update of one cell) is taken when start is high
// and busy is low. Configuration registers are written over cfg_valid/cfg_ready with
// a register index and 64 bits of data, only while busy is low.
// Load and prepare give no result. An update gives one result, shown for one cycle
// with result_valid in the first cycle after busy falls; the receiver cannot stall it.
// Steps: a load writes the cell; a prepare reads it and copies in the neighbor at its
//   first Neumann face; a ghost update only reports; other updates sum six neighbors,
//   scale, accumulate and divide, bypassing the divider on saturation or zero divide.
// The six neighbor reads go one at a time through the single read port of the
// previous-value memory, and the relative change comes from a restoring divider
// that retires one quotient bit per cycle (32 bits).
// Cell state sits in two memories of CELLS words: {flags, reaction, concentration}
// and the latched previous value. Neither needs clearing after reset; reading a
// never-written cell is not supported. CELLS must be a power of two, so cell and
// neighbor addresses wrap modulo CELLS. Reset clears control state, the running
// maximum and configuration (row and plane length reset to 1).
module diffusion_reaction_stencil_unit #(
	parameter int CELLS = 32768
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  drs_pkg::item_t   item,
	output logic             result_valid,
	output drs_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data
);

	localparam int AW = $clog2(CELLS);

	typedef enum logic [11:0] {
		S_IDLE  = 12'h001,
		S_LOAD  = 12'h002,
		S_RD    = 12'h004,
		S_PREP  = 12'h008,
		S_PCOPY = 12'h010,
		S_UPD   = 12'h020,
		S_SUM   = 12'h040,
		S_MUL   = 12'h080,
		S_ACC   = 12'h100,
		S_DSET  = 12'h200,
		S_DIV   = 12'h400,
		S_OUT   = 12'h800
	} state_t;

	typedef struct packed {
		logic [6:0]  flags;
		logic [31:0] reac;
		logic [31:0] conc;
	} cell_word_t;

	// configuration
	logic [63:0] dx_q, dy_q, dz_q;
	logic [11:0] modes_q;
	logic [15:0] gain_q;
	logic [31:0] dt_q;
	logic [15:0] row_q, plane_q;

	state_t      state_q;
	logic [1:0]  kind_q;
	logic [14:0] raw_idx_q;
	logic [AW-1:0] idx_q;
	logic [6:0]  flags_q;
	logic [31:0] reac_q, conc_q, p_q;
	logic [2:0]  cnt_q;
	logic [34:0] sum_q;
	logic [56:0] prod_q;
	logic        neg_q;
	logic signed [53:0] mul_q;
	logic [31:0] newc_q;
	logic [31:0] rem_q, dvd_q, quo_q;
	logic [4:0]  dcnt_q;
	logic        zdiv_q;
	logic [31:0] runmax_q;
	logic        result_valid_q;
	drs_pkg::result_t result_q;

	// memories
	cell_word_t  mem_a [CELLS];
	logic [31:0] mem_b [CELLS];
	cell_word_t  rd_a_q;
	logic [31:0] rd_b_q;
	logic        a_we, b_we;
	logic [AW-1:0] a_raddr, b_raddr;
	cell_word_t  a_wdata;
	logic [31:0] b_wdata;

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = !busy;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// neighbor address for a face
	logic [2:0]    nb_face;
	logic [AW-1:0] nb_step, nb_addr;
	always_comb begin
		unique case (nb_face)
			3'd0, 3'd1: nb_step = AW'(1);
			3'd2, 3'd3: nb_step = AW'(row_q);
			default:    nb_step = AW'(plane_q);
		endcase
		nb_addr = nb_face[0] ? (idx_q - nb_step) : (idx_q + nb_step);
	end

	// first Dirichlet face of a load item
	logic        dir_hit;
	logic [31:0] dir_val;
	always_comb begin
		logic [63:0] pair;
		dir_hit = 1'b0;
		dir_val = '0;
		for (int f = drs_pkg::NUM_FACES - 1; f >= 0; f--) begin
			pair = (f < 2) ? dx_q : (f < 4) ? dy_q : dz_q;
			if (flags_q[f] && modes_q[2*f +: 2] == drs_pkg::MODE_DIRICHLET) begin
				dir_hit = 1'b1;
				dir_val = pair[32*(f%2) +: 32];
			end
		end
	end

	// first Neumann face of the stored cell
	logic       neu_hit;
	logic [2:0] neu_face;
	always_comb begin
		neu_hit  = 1'b0;
		neu_face = '0;
		for (int f = drs_pkg::NUM_FACES - 1; f >= 0; f--) begin
			if (rd_a_q.flags[f] && modes_q[2*f +: 2] == drs_pkg::MODE_NEUMANN) begin
				neu_hit  = 1'b1;
				neu_face = 3'(f);
			end
		end
	end

	// arithmetic
	logic [31:0] mag_c;
	logic [63:0] prod_c;
	logic [34:0] six_p;
	logic signed [36:0] lap_c;
	logic signed [63:0] acc_c, term_c;
	logic [63:0] rnd_c;
	logic [31:0] newc_c, diff_c;
	logic [32:0] trial_c;

	always_comb begin
		mag_c  = rd_a_q.reac[31] ? (32'd0 - rd_a_q.reac) : rd_a_q.reac;
		prod_c = 64'(dt_q) * 64'(mag_c);
		six_p  = 35'({p_q, 2'b00}) + 35'({p_q, 1'b0});
		lap_c  = $signed({2'b00, sum_q}) - $signed({2'b00, six_p});
		term_c = neg_q ? -$signed({7'd0, prod_q}) : $signed({7'd0, prod_q});
		acc_c  = $signed({16'd0, p_q, 16'd0}) + 64'(mul_q) + term_c;
		rnd_c  = $unsigned(acc_c) + 64'h8000;
		if (acc_c <= 0)
			newc_c = '0;
		else if (|rnd_c[63:48])
			newc_c = '1;
		else
			newc_c = rnd_c[47:16];
		diff_c  = (newc_q >= p_q) ? (newc_q - p_q) : (p_q - newc_q);
		trial_c = {rem_q, dvd_q[31]};
	end

	// memory port control
	always_comb begin
		a_we    = 1'b0;
		b_we    = 1'b0;
		a_raddr = idx_q;
		b_raddr = idx_q;
		a_wdata = '{flags: flags_q, reac: reac_q, conc: conc_q};
		b_wdata = rd_a_q.conc;
		nb_face = cnt_q;
		unique case (state_q)
			S_LOAD: begin
				a_we    = 1'b1;
				a_wdata = '{flags: flags_q, reac: reac_q,
					conc: dir_hit ? dir_val : conc_q};
			end
			S_PREP: begin
				nb_face = neu_face;
				a_raddr = nb_addr;
				b_we    = !neu_hit;
			end
			S_PCOPY: begin
				a_we    = 1'b1;
				a_wdata = '{flags: flags_q, reac: reac_q, conc: rd_a_q.conc};
				b_we    = 1'b1;
			end
			S_SUM: begin
				b_raddr = nb_addr;
			end
			S_ACC: begin
				a_we    = 1'b1;
				a_wdata = '{flags: flags_q, reac: reac_q, conc: newc_c};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we)
			mem_a[idx_q] <= a_wdata;
		if (b_we)
			mem_b[idx_q] <= b_wdata;
		rd_a_q <= mem_a[a_raddr];
		rd_b_q <= mem_b[b_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q    <= '0;
			dy_q    <= '0;
			dz_q    <= '0;
			modes_q <= '0;
			gain_q  <= '0;
			dt_q    <= '0;
			row_q   <= 16'd1;
			plane_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				drs_pkg::REG_DIRICHLET_X:  dx_q    <= cfg_data;
				drs_pkg::REG_DIRICHLET_Y:  dy_q    <= cfg_data;
				drs_pkg::REG_DIRICHLET_Z:  dz_q    <= cfg_data;
				drs_pkg::REG_BOUNDARY:     modes_q <= cfg_data[11:0];
				drs_pkg::REG_GAIN:         gain_q  <= cfg_data[15:0];
				drs_pkg::REG_TIME_STEP:    dt_q    <= cfg_data[31:0];
				drs_pkg::REG_ROW_LENGTH:   row_q   <= cfg_data[15:0];
				drs_pkg::REG_PLANE_LENGTH: plane_q <= cfg_data[15:0];
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			runmax_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// ghost update reports right after its read, others after S_OUT
			result_valid_q <= (state_q == S_OUT) || (state_q == S_UPD && rd_a_q.flags[6]);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (item.kind == drs_pkg::KIND_LOAD)
							state_q <= S_LOAD;
						else if (item.kind == drs_pkg::KIND_PREPARE ||
							item.kind == drs_pkg::KIND_UPDATE)
							state_q <= S_RD;
					end
				end
				S_LOAD: begin
					runmax_q <= '0;
					state_q  <= S_IDLE;
				end
				S_RD:
					state_q <= (kind_q == drs_pkg::KIND_PREPARE) ? S_PREP : S_UPD;
				S_PREP:
					state_q <= neu_hit ? S_PCOPY : S_IDLE;
				S_PCOPY:
					state_q <= S_IDLE;
				S_UPD:
					state_q <= rd_a_q.flags[6] ? S_IDLE : S_SUM;
				S_SUM:
					if (cnt_q == 3'd6)
						state_q <= S_MUL;
				S_MUL:
					state_q <= S_ACC;
				S_ACC:
					state_q <= S_DSET;
				S_DSET:
					state_q <= (p_q == '0 || {16'd0, diff_c[31:16]} >= p_q) ? S_OUT : S_DIV;
				S_DIV:
					if (dcnt_q == 5'd31)
						state_q <= S_OUT;
				S_OUT: begin
					if (quo_q > runmax_q)
						runmax_q <= quo_q;
					state_q <= S_IDLE;
				end
				default:
					state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q    <= item.kind;
				raw_idx_q <= item.cell_index;
				idx_q     <= AW'(item.cell_index);
				conc_q    <= item.concentration;
				reac_q    <= item.reaction;
				flags_q   <= {item.ghost_flag, item.face_flags};
			end
			S_PREP: begin
				flags_q <= rd_a_q.flags;
				reac_q  <= rd_a_q.reac;
			end
			S_UPD: begin
				flags_q <= rd_a_q.flags;
				reac_q  <= rd_a_q.reac;
				p_q     <= rd_b_q;
				neg_q   <= rd_a_q.reac[31];
				prod_q  <= (prod_c > 64'h0100_0000_0000_0000) ? {1'b1, 56'd0} : prod_c[56:0];
				cnt_q   <= '0;
				sum_q   <= '0;
				// ghost cell: report stored value unchanged
				result_q <= '{result_index: raw_idx_q, new_concentration: rd_a_q.conc,
					relative_change: '0, max_change: runmax_q, zero_divide: 1'b0};
			end
			S_SUM: begin
				// read for face cnt goes out now, its data lands in the next cycle
				if (cnt_q != 3'd0)
					sum_q <= sum_q + 35'(rd_b_q);
				cnt_q <= cnt_q + 3'd1;
			end
			S_MUL:
				mul_q <= $signed({1'b0, gain_q}) * lap_c;
			S_ACC:
				newc_q <= newc_c;
			S_DSET: begin
				zdiv_q <= (p_q == '0);
				quo_q  <= (p_q != '0 && {16'd0, diff_c[31:16]} < p_q) ?
					32'd0 : 32'hFFFF_FFFF;
				rem_q  <= {16'd0, diff_c[31:16]};
				dvd_q  <= {diff_c[15:0], 16'd0};
				dcnt_q <= '0;
			end
			S_DIV: begin
				if (trial_c >= {1'b0, p_q}) begin
					rem_q <= 32'(trial_c - {1'b0, p_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= trial_c[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				dvd_q  <= {dvd_q[30:0], 1'b0};
				dcnt_q <= dcnt_q + 5'd1;
			end
			S_OUT:
				result_q <= '{result_index: raw_idx_q, new_concentration: newc_q,
					relative_change: quo_q,
					max_change: (quo_q > runmax_q) ? quo_q : runmax_q,
					zero_divide: zdiv_q};
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/drs_checker.sv]
// Port-level checker for the stencil unit, bound to the top level.
// Depends on drs_pkg and diffusion_reaction_stencil_unit_assert.svh.
`include "diffusion_reaction_stencil_unit_assert.svh"

module drs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input drs_pkg::item_t   item,
	input logic             result_valid,
	input drs_pkg::result_t result
);

	`DRS_ASSERT_NEXT(a_result_gap, result_valid, !result_valid)
	`DRS_ASSERT_NEXT(a_load_busy, start && !busy && item.kind == drs_pkg::KIND_LOAD, busy)
	`DRS_ASSERT_SAME(a_zdiv_sat, result_valid && result.zero_divide, result.relative_change == 32'hFFFF_FFFF)
	`DRS_ASSERT_SAME(a_max_bound, result_valid, result.max_change >= result.relative_change)

endmodule

bind diffusion_reaction_stencil_unit drs_checker u_drs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

[tb/diffusion_reaction_stencil_unit_tb.sv]
// Self-checking testbench for diffusion_reaction_stencil_unit: loads, prepares and updates
// cells under several register settings and checks every update result against a predictor.
// Depends on drs_pkg and the unit RTL.
`timescale 1ns / 100ps

module diffusion_reaction_stencil_unit_tb;

	localparam int CELLS      = 32768;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 60;

	// Stencil predictor plus the queue of updates still owed by the unit.
	class stencil_scoreboard;
		logic [31:0] conc_mem [CELLS];
		logic [31:0] prev_mem [CELLS];
		logic [31:0] reac_mem [CELLS];
		logic [6:0]  flag_mem [CELLS];
		bit          loaded [CELLS];
		bit          latched [CELLS];
		logic [31:0] run_max;
		logic [63:0] dir_x, dir_y, dir_z;
		logic [11:0] modes;
		logic [15:0] gain, row_len, plane_len;
		logic [31:0] dt;
		drs_pkg::result_t owed [$];
		int          mismatches, checked, zero_divs, ghosts;

		function new();
			run_max = 0; dir_x = 0; dir_y = 0; dir_z = 0; modes = 0;
			gain = 0; dt = 0; row_len = 1; plane_len = 1;
			mismatches = 0; checked = 0; zero_divs = 0; ghosts = 0;
		endfunction

		function void configure(logic [2:0] idx, logic [63:0] data);
			case (idx)
				drs_pkg::REG_DIRICHLET_X:  dir_x = data;
				drs_pkg::REG_DIRICHLET_Y:  dir_y = data;
				drs_pkg::REG_DIRICHLET_Z:  dir_z = data;
				drs_pkg::REG_BOUNDARY:     modes = data[11:0];
				drs_pkg::REG_GAIN:         gain = data[15:0];
				drs_pkg::REG_TIME_STEP:    dt = data[31:0];
				drs_pkg::REG_ROW_LENGTH:   row_len = data[15:0];
				drs_pkg::REG_PLANE_LENGTH: plane_len = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [1:0] mode_of(int f);
			return modes[2*f +: 2];
		endfunction

		function int neighbor(int i, int f);
			int step;
			step = (f < 2) ? 1 : (f < 4) ? row_len : plane_len;
			step = step % CELLS;
			return (f % 2) ? (i + CELLS - step) % CELLS : (i + step) % CELLS;
		endfunction

		// first flagged Neumann face, or -1
		function int neumann_face(int i);
			for (int f = 0; f < drs_pkg::NUM_FACES; f++)
				if (flag_mem[i][f] && mode_of(f) == drs_pkg::MODE_NEUMANN) return f;
			return -1;
		endfunction

		// true when the item never reads a cell that was not written
		function bit legal(drs_pkg::item_t it);
			int i, f;
			i = it.cell_index;
			case (it.kind)
				drs_pkg::KIND_PREPARE: begin
					if (!loaded[i]) return 0;
					f = neumann_face(i);
					return f < 0 || loaded[neighbor(i, f)];
				end
				drs_pkg::KIND_UPDATE: begin
					if (!loaded[i]) return 0;
					if (flag_mem[i][6]) return 1;
					if (!latched[i]) return 0;
					for (int k = 0; k < drs_pkg::NUM_FACES; k++)
						if (!latched[neighbor(i, k)]) return 0;
					return 1;
				end
				default: return 1;
			endcase
		endfunction

		function void note(drs_pkg::item_t it);
			int i, f;
			longint p, lap, acc, term, q;
			logic [63:0] mag, prod, diff;
			drs_pkg::result_t r;
			i = it.cell_index;
			case (it.kind)
				drs_pkg::KIND_LOAD: begin
					conc_mem[i] = it.concentration;
					reac_mem[i] = it.reaction;
					flag_mem[i] = {it.ghost_flag, it.face_flags};
					loaded[i] = 1;
					for (f = 0; f < drs_pkg::NUM_FACES; f++)
						if (it.face_flags[f] && mode_of(f) == drs_pkg::MODE_DIRICHLET) begin
							conc_mem[i] = (f < 2) ? dir_x[32*(f%2) +: 32] :
								(f < 4) ? dir_y[32*(f%2) +: 32] : dir_z[32*(f%2) +: 32];
							break;
						end
					run_max = 0;
				end
				drs_pkg::KIND_PREPARE: begin
					f = neumann_face(i);
					if (f >= 0) conc_mem[i] = conc_mem[neighbor(i, f)];
					prev_mem[i] = conc_mem[i];
					latched[i] = 1;
				end
				drs_pkg::KIND_UPDATE: begin
					r.result_index = it.cell_index;
					r.relative_change = 0;
					r.zero_divide = 0;
					if (flag_mem[i][6]) begin
						r.new_concentration = conc_mem[i];
						ghosts++;
					end else begin
						p = prev_mem[i];
						lap = -6 * p;
						for (f = 0; f < drs_pkg::NUM_FACES; f++)
							lap += prev_mem[neighbor(i, f)];
						mag = reac_mem[i][31] ? {32'd0, -reac_mem[i]} : {32'd0, reac_mem[i]};
						prod = {32'd0, dt} * mag;
						if (prod > 64'h0100_0000_0000_0000) prod = 64'h0100_0000_0000_0000;
						term = reac_mem[i][31] ? -longint'(prod) : longint'(prod);
						acc = (p <<< 16) + longint'(gain) * lap + term;
						if (acc <= 0) r.new_concentration = 0;
						else begin
							q = (acc + 'h8000) >>> 16;
							r.new_concentration = (q > 'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
						end
						conc_mem[i] = r.new_concentration;
						diff = (r.new_concentration >= p) ? r.new_concentration - p :
							p - r.new_concentration;
						if (p == 0) begin
							r.relative_change = 32'hFFFF_FFFF;
							r.zero_divide = 1;
							zero_divs++;
						end else begin
							q = (diff << 16) / p;
							r.relative_change = (q > 'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
						end
						if (r.relative_change > run_max) run_max = r.relative_change;
					end
					r.max_change = run_max;
					owed.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check(drs_pkg::result_t got);
			drs_pkg::result_t exp;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: index %0d conc %h", got.result_index,
						got.new_concentration);
				return;
			end
			exp = owed.pop_front();
			checked++;
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch cell %0d: exp conc %h rel %h max %h zd %b / got idx %0d conc %h rel %h max %h zd %b",
						exp.result_index, exp.new_concentration, exp.relative_change,
						exp.max_change, exp.zero_divide, got.result_index,
						got.new_concentration, got.relative_change, got.max_change,
						got.zero_divide);
			end
		endfunction
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             start = 0;
	logic             busy;
	drs_pkg::item_t   item = '0;
	logic             result_valid;
	drs_pkg::result_t result;
	logic             cfg_valid = 0;
	logic             cfg_ready;
	logic [2:0]       cfg_index = drs_pkg::REG_DIRICHLET_X;
	logic [63:0]      cfg_data = '0;

	stencil_scoreboard sb = new();
	int items_taken = 0, cfg_taken = 0, idle_cycles = 0, phases_run = 0;

	always #2 clk = ~clk;

	diffusion_reaction_stencil_unit #(.CELLS(CELLS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// sampled before the unit's own updates land at this edge
	always @(posedge clk) begin
		idle_cycles++;
		if (arst_n && start && !busy) begin
			sb.note(item);
			items_taken++;
			idle_cycles = 0;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			sb.configure(cfg_index, cfg_data);
			cfg_taken++;
			idle_cycles = 0;
		end
		if (arst_n && result_valid) begin
			sb.check(result);
			idle_cycles = 0;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[diffusion_reaction_stencil_unit] ERROR");
			$finish;
		end
	end

	task automatic pause_sender();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) start = 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send(drs_pkg::item_t it);
		int seen;
		pause_sender();
		seen = items_taken;
		item = it;
		start = 1;
		do @(negedge clk); while (items_taken == seen);
	endtask

	// wait until the unit owes nothing and has finished any silent item
	task automatic drain();
		start = 0;
		do @(negedge clk); while (sb.owed.size() != 0 || busy);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		int seen;
		seen = cfg_taken;
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(negedge clk); while (cfg_taken == seen);
		cfg_valid = 0;
	endtask

	function automatic drs_pkg::item_t make_item(logic [1:0] kind, int idx);
		drs_pkg::item_t it;
		it.kind = kind;
		it.cell_index = idx[14:0];
		case ($urandom_range(0, 9))
			0: it.concentration = 32'd0;
			1, 2, 3, 4: it.concentration = $urandom_range(0, 32'h0004_0000);
			default: it.concentration = $urandom;
		endcase
		it.reaction = $urandom_range(0, 1) ? 32'($urandom) :
			32'($signed($urandom_range(0, 'h2000)) - 'h1000);
		it.face_flags = ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'd0;
		it.ghost_flag = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	// item that is legal now; falls back to a load of the same cell
	task automatic send_legal(drs_pkg::item_t it);
		if (!sb.legal(it)) it.kind = drs_pkg::KIND_LOAD;
		send(it);
	endtask

	task automatic run_phase(logic [15:0] gain, logic [31:0] dt, logic [15:0] row,
		logic [15:0] plane, int count);
		int base, eff, span, pick;
		drs_pkg::item_t it;
		drain();
		write_reg(drs_pkg::REG_DIRICHLET_X, {$urandom, $urandom});
		write_reg(drs_pkg::REG_DIRICHLET_Y, {$urandom, $urandom});
		write_reg(drs_pkg::REG_DIRICHLET_Z,
			(phases_run == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0);
		write_reg(drs_pkg::REG_BOUNDARY,
			(phases_run == 1) ? 64'hFFF : 64'($urandom_range(0, 4095)));
		write_reg(drs_pkg::REG_GAIN, 64'(gain));
		write_reg(drs_pkg::REG_TIME_STEP, 64'(dt));
		write_reg(drs_pkg::REG_ROW_LENGTH, 64'(row));
		write_reg(drs_pkg::REG_PLANE_LENGTH, 64'(plane));
		phases_run++;
		eff = plane % CELLS;
		base = $urandom_range(0, 20000);
		span = 2 * eff + 8;
		for (int c = 0; c < span; c++) begin
			it = make_item(drs_pkg::KIND_LOAD, base + c);
			it.ghost_flag = 0;
			send(it);
		end
		for (int c = 0; c < span; c++)
			send_legal(make_item(drs_pkg::KIND_PREPARE, base + c));
		for (int n = 0; n < count; n++) begin
			pick = ($urandom_range(0, 9) < 7) ? base + eff + $urandom_range(0, 7) :
				$urandom_range(0, CELLS - 1);
			case ($urandom_range(0, 9))
				0, 1, 2: it = make_item(drs_pkg::KIND_LOAD, pick);
				3, 4, 5: it = make_item(drs_pkg::KIND_PREPARE, pick);
				default: it = make_item(drs_pkg::KIND_UPDATE, pick);
			endcase
			send_legal(it);
			if (n == count / 2 && phases_run == 1) drain();
		end
	endtask

	initial begin
		drs_pkg::item_t it;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, ghost and zero-previous cases, unused kind
		write_reg(drs_pkg::REG_BOUNDARY, 64'h000);
		it = '0;
		it.kind = drs_pkg::KIND_LOAD; it.cell_index = 15'h7FFF;
		it.concentration = 32'hFFFF_FFFF;
		it.reaction = 32'sh7FFF_FFFF; it.face_flags = 6'h3F;
		send(it);
		it.kind = drs_pkg::KIND_LOAD; it.cell_index = 15'd0; it.concentration = 32'd0;
		it.reaction = 32'sh8000_0000; it.face_flags = 6'd0; it.ghost_flag = 1'b0;
		send(it);
		it.cell_index = 15'd1; send(it);
		it.cell_index = 15'h7FFE; send(it);
		it.cell_index = 15'd2; it.ghost_flag = 1'b1; it.concentration = 32'h1234_5678;
		send(it);
		it.kind = 2'd3; send(it);
		for (int c = 0; c < 3; c++) begin
			it.kind = drs_pkg::KIND_PREPARE; it.cell_index = 15'(c); send(it);
		end
		it.cell_index = 15'h7FFF; send(it);
		it.cell_index = 15'h7FFE; send(it);
		it.kind = drs_pkg::KIND_UPDATE; it.cell_index = 15'd0; send(it);
		it.cell_index = 15'd1; send(it);
		it.cell_index = 15'd2; send(it);

		run_phase(16'h1000, 32'h0000_0100, 16'd2, 16'd4, 50);
		run_phase(16'hFFFF, 32'hFFFF_FFFF, 16'd1, 16'd1, 50);
		run_phase(16'h0000, 32'h0000_0000, 16'd32768, 16'd32768, 50);
		run_phase(16'h0800, 32'h0001_0000, 16'd3, 16'd12, 40);
		run_phase(16'($urandom), $urandom_range(0, 32'h10000), 16'd4, 16'd8, 40);

		drain();
		$display("covered %0d items over %0d register settings: %0d updates checked,",
			items_taken, phases_run + 1, sb.checked);
		$display("  %0d ghost updates, %0d zero-previous updates, %0d mismatches",
			sb.ghosts, sb.zero_divs, sb.mismatches);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("[diffusion_reaction_stencil_unit] OK");
		else
			$display("[diffusion_reaction_stencil_unit] ERROR");
		$finish;
	end

endmodule
